@@ rtl/tdfsm_pkg.sv @@
`timescale 1ns / 1ps

package tdfsm_pkg;

    // Default sizing
    localparam int DEF_NUM_ENTRIES = 16;
    localparam int DEF_QUEUE_SLOTS = 4;
    localparam int DEF_STATE_BITS  = 4;
    localparam int DEF_EVENT_BITS  = 4;

    // Action mask registers
    localparam int MASK_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MASK = 2'd2;

    // Request codes
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POST   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    // Result kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_APPEND_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POST_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 2'd3;

    // Sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_fsm;

    // Table cell control
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Event ring control and status
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_sts;

endpackage

@@ rtl/tdfsm_cell.sv @@
`timescale 1ns / 1ps

// One transition table slot: loads on append, rotates toward cell 0 on scan.
module tdfsm_cell import tdfsm_pkg::*; #(
    parameter int ENTRY_W = 3 * DEF_STATE_BITS
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [ENTRY_W-1:0] i_load_data,
    input  logic [ENTRY_W-1:0] i_shift_data,
    output logic [ENTRY_W-1:0] o_entry
);

    logic [ENTRY_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_shift_data;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/tdfsm_ring.sv @@
`timescale 1ns / 1ps

// Event ring; one slot stays unused. Writes go to next(head), reads from next(tail).
module tdfsm_ring import tdfsm_pkg::*; #(
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
    parameter int EVENT_BITS  = DEF_EVENT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ring_ctl             i_ctl,
    input  logic [EVENT_BITS-1:0] i_push_data,
    output t_ring_sts             o_sts,
    output logic [EVENT_BITS-1:0] o_pop_data
);

    localparam int PW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

    logic [EVENT_BITS-1:0] r_slot [QUEUE_SLOTS];
    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_tail;
    logic [PW-1:0]         w_head_nx;
    logic [PW-1:0]         w_tail_nx;

    assign w_head_nx = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;

    assign o_sts.full  = (w_head_nx == r_tail);
    assign o_sts.empty = (r_head == r_tail);
    assign o_pop_data  = r_slot[w_tail_nx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_ctl.push) begin
                r_head <= w_head_nx;
            end
            if (i_ctl.pop) begin
                r_tail <= w_tail_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_slot[w_head_nx] <= i_push_data;
        end
    end

endmodule

@@ rtl/table_driven_fsm_with_event_queue_top.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Beat
// --------+-----------+---------------------------+------------------------------------
// in      | input     | i_in_valid / o_in_stall   | request: type, transition, event
// out     | output    | o_out_valid / i_out_stall | result: kind, flags, states, last
// cfg     | input     | i_cfg_we                  | action mask write (idx, data)
//
// Append and post each give one ack beat.
// A tick with an empty ring gives only its done beat; otherwise the table
// rotates once through the cell chain, one entry per cycle unless a fired beat
// waits on an out stall, then gives its done beat once the out side is free.
// Synchronous active-low reset clears the entry count, ring pointers, state and masks.
// One output register between the sides; requests wait during a tick or a stalled beat.
module table_driven_fsm_with_event_queue_top import tdfsm_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
    parameter int STATE_BITS  = DEF_STATE_BITS,
    parameter int EVENT_BITS  = DEF_EVENT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // config
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [MASK_W-1:0]     i_cfg_data,

    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [STATE_BITS-1:0] i_from_state,
    input  logic [EVENT_BITS-1:0] i_on_event,
    input  logic [STATE_BITS-1:0] i_to_state,
    input  logic [EVENT_BITS-1:0] i_event_code,

    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [KIND_W-1:0]     o_result_kind,
    output logic                  o_accepted,
    output logic                  o_event_taken,
    output logic [EVENT_BITS-1:0] o_taken_event,
    output logic [STATE_BITS-1:0] o_exit_state,
    output logic                  o_exit_fire,
    output logic [STATE_BITS-1:0] o_entry_state,
    output logic                  o_entry_fire,
    output logic [STATE_BITS-1:0] o_current_state,
    output logic                  o_update_fire,
    output logic                  o_last
);

    localparam int ENTRY_W = 2 * STATE_BITS + EVENT_BITS;
    localparam int IDXW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNTW    = $clog2(NUM_ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_ENTRIES - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(NUM_ENTRIES);

    // action bit of a state; states past the mask width have none
    function automatic logic mask_bit(input logic [MASK_W-1:0] m, input logic [7:0] s);
        logic r;
        r = (s[7:4] == 4'd0) ? m[s[3:0]] : 1'b0;
        return r;
    endfunction

    // ---------------- registers ----------------
    t_fsm                  r_fsm, n_fsm;
    logic [CNTW-1:0]       r_count;
    logic [IDXW-1:0]       r_scan_idx;
    logic [STATE_BITS-1:0] r_state;     // machine state
    logic [STATE_BITS-1:0] r_next;      // state after the running tick
    logic [EVENT_BITS-1:0] r_event;     // event taken by the running tick
    logic [MASK_W-1:0]     r_exit_mask;
    logic [MASK_W-1:0]     r_entry_mask;
    logic [MASK_W-1:0]     r_update_mask;

    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind,   n_kind;
    logic                  r_acc,    n_acc;
    logic                  r_taken,  n_taken;
    logic [EVENT_BITS-1:0] r_tev,    n_tev;
    logic [STATE_BITS-1:0] r_xs,     n_xs;
    logic                  r_xf,     n_xf;
    logic [STATE_BITS-1:0] r_ns,     n_ns;
    logic                  r_nf,     n_nf;
    logic [STATE_BITS-1:0] r_cs,     n_cs;
    logic                  r_uf,     n_uf;
    logic                  r_last,   n_last;

    // ---------------- control nets ----------------
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_append_ok;
    logic                  w_tick_go;
    logic                  w_load_out;
    logic                  w_hit;
    logic                  w_step;
    logic                  w_in_range;
    t_ring_ctl             w_ring_ctl;
    t_ring_sts             w_ring_sts;
    logic [EVENT_BITS-1:0] w_pop_data;

    logic [ENTRY_W-1:0]    w_entry [NUM_ENTRIES];
    logic [ENTRY_W-1:0]    w_new_entry;
    logic [STATE_BITS-1:0] w_src;
    logic [EVENT_BITS-1:0] w_ev;
    logic [STATE_BITS-1:0] w_dst;

    // ---------------- table: rotating chain of cells ----------------
    assign w_new_entry = {i_from_state, i_on_event, i_to_state};

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.load  = w_append_ok && (r_count == CNTW'(g));
        assign w_ctl.shift = w_step;

        tdfsm_cell #(
            .ENTRY_W (ENTRY_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_load_data  (w_new_entry),
            .i_shift_data (w_entry[(g + 1) % NUM_ENTRIES]),
            .o_entry      (w_entry[g])
        );
    end

    // cell 0 holds original entry r_scan_idx during a scan
    assign w_src = w_entry[0][ENTRY_W-1 -: STATE_BITS];
    assign w_ev  = w_entry[0][STATE_BITS +: EVENT_BITS];
    assign w_dst = w_entry[0][STATE_BITS-1:0];

    // ---------------- event ring ----------------
    tdfsm_ring #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .EVENT_BITS  (EVENT_BITS)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ring_ctl),
        .i_push_data (i_event_code),
        .o_sts       (w_ring_sts),
        .o_pop_data  (w_pop_data)
    );

    // ---------------- handshake and scan control ----------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_fsm == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_append_ok = w_accept && (i_req_type == REQ_APPEND) && (r_count < FULL_CNT);
    assign w_tick_go   = w_accept && (i_req_type == REQ_TICK) && !w_ring_sts.empty;

    assign w_ring_ctl.push = w_accept && (i_req_type == REQ_POST) && !w_ring_sts.full;
    assign w_ring_ctl.pop  = w_tick_go;

    // r_state holds the state from before the tick until DONE
    assign w_in_range = (CNTW'(r_scan_idx) < r_count);
    assign w_hit  = (r_fsm == S_SCAN) && w_in_range && (w_src == r_state)
                    && (w_ev == r_event);
    // hold the chain while a fired beat cannot be placed
    assign w_step = (r_fsm == S_SCAN) && (!w_hit || w_out_free);

    // ---------------- next state ----------------
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (w_tick_go) begin
                    n_fsm = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step && (r_scan_idx == LAST_IDX)) begin
                    n_fsm = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    // ---------------- result beat ----------------
    always_comb begin
        w_load_out = 1'b0;
        n_kind  = KIND_APPEND_ACK;
        n_acc   = 1'b0;
        n_taken = 1'b0;
        n_tev   = '0;
        n_xs    = '0;
        n_xf    = 1'b0;
        n_ns    = '0;
        n_nf    = 1'b0;
        n_cs    = '0;
        n_uf    = 1'b0;
        n_last  = 1'b0;
        unique case (r_fsm)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        REQ_APPEND: begin
                            w_load_out = 1'b1;
                            n_kind     = KIND_APPEND_ACK;
                            n_acc      = (r_count < FULL_CNT);
                            n_last     = 1'b1;
                        end
                        REQ_POST: begin
                            w_load_out = 1'b1;
                            n_kind     = KIND_POST_ACK;
                            n_acc      = !w_ring_sts.full;
                            n_last     = 1'b1;
                        end
                        REQ_TICK: begin
                            // empty ring: done beat right away
                            if (w_ring_sts.empty) begin
                                w_load_out = 1'b1;
                                n_kind     = KIND_TICK_DONE;
                                n_cs       = r_state;
                                n_uf       = mask_bit(r_update_mask, 8'(r_state));
                                n_last     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit && w_out_free) begin
                    w_load_out = 1'b1;
                    n_kind     = KIND_FIRED;
                    n_taken    = 1'b1;
                    n_tev      = r_event;
                    n_xs       = w_src;
                    n_xf       = mask_bit(r_exit_mask, 8'(w_src));
                    n_ns       = w_dst;
                    n_nf       = mask_bit(r_entry_mask, 8'(w_dst));
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_kind     = KIND_TICK_DONE;
                    n_taken    = 1'b1;
                    n_tev      = r_event;
                    n_cs       = r_next;
                    n_uf       = mask_bit(r_update_mask, 8'(r_next));
                    n_last     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm         <= S_IDLE;
            r_count       <= '0;
            r_scan_idx    <= '0;
            r_state       <= '0;
            r_out_valid   <= 1'b0;
            r_exit_mask   <= '0;
            r_entry_mask  <= '0;
            r_update_mask <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (w_append_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (w_tick_go) begin
                r_scan_idx <= '0;
            end else if (w_step) begin
                r_scan_idx <= (r_scan_idx == LAST_IDX) ? '0 : r_scan_idx + 1'b1;
            end
            if ((r_fsm == S_DONE) && w_out_free) begin
                r_state <= r_next;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXIT_MASK:   r_exit_mask   <= i_cfg_data;
                    CFG_ENTRY_MASK:  r_entry_mask  <= i_cfg_data;
                    CFG_UPDATE_MASK: r_update_mask <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- tick payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_tick_go) begin
            r_event <= w_pop_data;
            r_next  <= r_state;
        end else if (w_step && w_hit) begin
            // last match wins
            r_next <= w_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_taken <= n_taken;
            r_tev   <= n_tev;
            r_xs    <= n_xs;
            r_xf    <= n_xf;
            r_ns    <= n_ns;
            r_nf    <= n_nf;
            r_cs    <= n_cs;
            r_uf    <= n_uf;
            r_last  <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_accepted      = r_acc;
    assign o_event_taken   = r_taken;
    assign o_taken_event   = r_tev;
    assign o_exit_state    = r_xs;
    assign o_exit_fire     = r_xf;
    assign o_entry_state   = r_ns;
    assign o_entry_fire    = r_nf;
    assign o_current_state = r_cs;
    assign o_update_fire   = r_uf;
    assign o_last          = r_last;

endmodule

@@ verif/tdfsm_result_checker.sv @@
`timescale 1ns / 1ps

module tdfsm_result_checker import tdfsm_pkg::*; #(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
    parameter int STATE_BITS  = DEF_STATE_BITS,
    parameter int EVENT_BITS  = DEF_EVENT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [MASK_W-1:0]     i_cfg_data,

    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [STATE_BITS-1:0] i_from_state,
    input  logic [EVENT_BITS-1:0] i_on_event,
    input  logic [STATE_BITS-1:0] i_to_state,
    input  logic [EVENT_BITS-1:0] i_event_code,

    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [KIND_W-1:0]     o_result_kind,
    input  logic                  o_accepted,
    input  logic                  o_event_taken,
    input  logic [EVENT_BITS-1:0] o_taken_event,
    input  logic [STATE_BITS-1:0] o_exit_state,
    input  logic                  o_exit_fire,
    input  logic [STATE_BITS-1:0] o_entry_state,
    input  logic                  o_entry_fire,
    input  logic [STATE_BITS-1:0] o_current_state,
    input  logic                  o_update_fire,
    input  logic                  o_last,

    output int                    o_errors,
    output int                    o_backlog,
    output int                    o_fired
);

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  accepted;
        logic                  taken;
        logic [EVENT_BITS-1:0] taken_code;
        logic [STATE_BITS-1:0] exit_st;
        logic                  exit_fire;
        logic [STATE_BITS-1:0] entry_st;
        logic                  entry_fire;
        logic [STATE_BITS-1:0] cur_st;
        logic                  update_fire;
        logic                  last;
    } t_beat;

    // shadow of the machine
    logic [STATE_BITS-1:0] tbl_from [NUM_ENTRIES];
    logic [EVENT_BITS-1:0] tbl_event [NUM_ENTRIES];
    logic [STATE_BITS-1:0] tbl_to [NUM_ENTRIES];
    int                    tbl_count;
    logic [EVENT_BITS-1:0] ring_code [QUEUE_SLOTS];
    int                    ring_head;
    int                    ring_tail;
    logic [STATE_BITS-1:0] fsm_state;
    logic [MASK_W-1:0]     exit_mask;
    logic [MASK_W-1:0]     entry_mask;
    logic [MASK_W-1:0]     update_mask;

    t_beat due_beats [$];
    int    mismatches = 0;
    int    fired_seen = 0;
    int    backlog    = 0;

    assign o_errors  = mismatches;
    assign o_backlog = backlog;
    assign o_fired   = fired_seen;

    function automatic logic action_bit(input logic [MASK_W-1:0] mask,
                                        input logic [STATE_BITS-1:0] st);
        if (int'(st) >= MASK_W) return 1'b0;
        return mask[st];
    endfunction

    function automatic int ring_advance(input int p);
        return (p + 1 >= QUEUE_SLOTS) ? 0 : p + 1;
    endfunction

    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic [STATE_BITS-1:0] from_st,
                                 input logic [EVENT_BITS-1:0] on_ev,
                                 input logic [STATE_BITS-1:0] to_st,
                                 input logic [EVENT_BITS-1:0] code_in);
        t_beat                 b;
        t_beat                 f;
        int                    nh;
        logic [STATE_BITS-1:0] nxt;
        logic [EVENT_BITS-1:0] code;
        b = '0;
        b.last = 1'b1;
        case (req)
            REQ_APPEND: begin
                b.kind = KIND_APPEND_ACK;
                if (tbl_count < NUM_ENTRIES) begin
                    tbl_from[tbl_count]  = from_st;
                    tbl_event[tbl_count] = on_ev;
                    tbl_to[tbl_count]    = to_st;
                    tbl_count++;
                    b.accepted = 1'b1;
                end
                due_beats.push_back(b);
            end
            REQ_POST: begin
                b.kind = KIND_POST_ACK;
                nh = ring_advance(ring_head);
                if (nh != ring_tail) begin
                    ring_code[nh] = code_in;
                    ring_head = nh;
                    b.accepted = 1'b1;
                end
                due_beats.push_back(b);
            end
            REQ_TICK: begin
                b.kind = KIND_TICK_DONE;
                if (ring_head != ring_tail) begin
                    ring_tail = ring_advance(ring_tail);
                    code = ring_code[ring_tail];
                    b.taken = 1'b1;
                    b.taken_code = code;
                    nxt = fsm_state;
                    // every match is matched against the state held before the tick
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_from[i] == fsm_state && tbl_event[i] == code) begin
                            f = '0;
                            f.kind       = KIND_FIRED;
                            f.taken      = 1'b1;
                            f.taken_code = code;
                            f.exit_st    = tbl_from[i];
                            f.exit_fire  = action_bit(exit_mask, tbl_from[i]);
                            f.entry_st   = tbl_to[i];
                            f.entry_fire = action_bit(entry_mask, tbl_to[i]);
                            due_beats.push_back(f);
                            nxt = tbl_to[i];
                        end
                    end
                    fsm_state = nxt;
                end
                b.cur_st = fsm_state;
                b.update_fire = action_bit(update_mask, fsm_state);
                due_beats.push_back(b);
            end
            default: ;  // unused code: no beat
        endcase
    endtask

    task automatic cmp(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_beat(input t_beat want);
        if (want.kind == KIND_FIRED) fired_seen++;
        cmp("result_kind", want.kind, o_result_kind);
        cmp("accepted", want.accepted, o_accepted);
        cmp("event_taken", want.taken, o_event_taken);
        cmp("taken_event", want.taken_code, o_taken_event);
        cmp("exit_state", want.exit_st, o_exit_state);
        cmp("exit_fire", want.exit_fire, o_exit_fire);
        cmp("entry_state", want.entry_st, o_entry_state);
        cmp("entry_fire", want.entry_fire, o_entry_fire);
        cmp("current_state", want.cur_st, o_current_state);
        cmp("update_fire", want.update_fire, o_update_fire);
        cmp("last", want.last, o_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count   = 0;
            ring_head   = 0;
            ring_tail   = 0;
            fsm_state   = '0;
            exit_mask   = '0;
            entry_mask  = '0;
            update_mask = '0;
            due_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXIT_MASK:   exit_mask = i_cfg_data;
                    CFG_ENTRY_MASK:  entry_mask = i_cfg_data;
                    CFG_UPDATE_MASK: update_mask = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                apply_request(i_req_type, i_from_state, i_on_event, i_to_state,
                              i_event_code);
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_beats.size() == 0) begin
                    $error("result beat of kind %0d with nothing expected", o_result_kind);
                    mismatches++;
                end else begin
                    compare_beat(due_beats.pop_front());
                end
            end
        end
        backlog <= due_beats.size();
    end

endmodule

@@ verif/tb_table_driven_fsm_with_event_queue_top.sv @@
`timescale 1ns / 1ps

module tb_table_driven_fsm_with_event_queue_top;
    import tdfsm_pkg::*;

    localparam int NUM_ENTRIES = DEF_NUM_ENTRIES;
    localparam int QUEUE_SLOTS = DEF_QUEUE_SLOTS;
    localparam int STATE_BITS  = DEF_STATE_BITS;
    localparam int EVENT_BITS  = DEF_EVENT_BITS;

    // req_type 3 has no meaning; the block must swallow it without a beat
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // settle time covers a full tick scan twice over, plus margin
    localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 8;
    // longest legal quiet spell is a long stall or gap plus one scan
    localparam int QUIET_LIMIT   = 2000;

    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 89;

    // Transition table loaded by the directed part, entry k at [k*12 +: 12],
    // each entry {from, event, to}. States 0/5/10/15 toggle every state bit,
    // events 0..3 and 15 cover every event bit. (0, 0) matches three times,
    // and the last of those (to 15) must win.
    localparam logic [16*12-1:0] SEED_TABLE = {
        12'h00F, 12'hA3A, 12'hF05, 12'h0F0, 12'h51F, 12'hA10, 12'h01A, 12'hF00,
        12'hA0F, 12'h50A, 12'h530, 12'hA25, 12'hF1A, 12'hFF0, 12'h00A, 12'h005
    };

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = CFG_EXIT_MASK;
    logic [MASK_W-1:0]     i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic [REQ_W-1:0]      i_req_type   = REQ_APPEND;
    logic [STATE_BITS-1:0] i_from_state = '0;
    logic [EVENT_BITS-1:0] i_on_event   = '0;
    logic [STATE_BITS-1:0] i_to_state   = '0;
    logic [EVENT_BITS-1:0] i_event_code = '0;
    logic                  i_out_stall  = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [KIND_W-1:0]     o_result_kind;
    logic                  o_accepted;
    logic                  o_event_taken;
    logic [EVENT_BITS-1:0] o_taken_event;
    logic [STATE_BITS-1:0] o_exit_state;
    logic                  o_exit_fire;
    logic [STATE_BITS-1:0] o_entry_state;
    logic                  o_entry_fire;
    logic [STATE_BITS-1:0] o_current_state;
    logic                  o_update_fire;
    logic                  o_last;

    int err_count;
    int backlog;
    int fired_count;

    // stimulus bookkeeping
    int items_sent   = 0;   // excludes ignored requests
    int n_append     = 0;
    int n_post       = 0;
    int n_tick       = 0;
    int n_ignored    = 0;
    int n_settings   = 0;
    bit steady_phase = 1'b0;  // no sender gaps while set
    int stall_hold   = 0;
    int quiet_cycles = 0;

    table_driven_fsm_with_event_queue_top #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .STATE_BITS  (STATE_BITS),
        .EVENT_BITS  (EVENT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_from_state    (i_from_state),
        .i_on_event      (i_on_event),
        .i_to_state      (i_to_state),
        .i_event_code    (i_event_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_accepted      (o_accepted),
        .o_event_taken   (o_event_taken),
        .o_taken_event   (o_taken_event),
        .o_exit_state    (o_exit_state),
        .o_exit_fire     (o_exit_fire),
        .o_entry_state   (o_entry_state),
        .o_entry_fire    (o_entry_fire),
        .o_current_state (o_current_state),
        .o_update_fire   (o_update_fire),
        .o_last          (o_last)
    );

    // Predicts every beat from the accepted requests and compares in order
    tdfsm_result_checker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .STATE_BITS  (STATE_BITS),
        .EVENT_BITS  (EVENT_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_from_state    (i_from_state),
        .i_on_event      (i_on_event),
        .i_to_state      (i_to_state),
        .i_event_code    (i_event_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_accepted      (o_accepted),
        .o_event_taken   (o_event_taken),
        .o_taken_event   (o_taken_event),
        .o_exit_state    (o_exit_state),
        .o_exit_fire     (o_exit_fire),
        .o_entry_state   (o_entry_state),
        .o_entry_fire    (o_entry_fire),
        .o_current_state (o_current_state),
        .o_update_fire   (o_update_fire),
        .o_last          (o_last),
        .o_errors        (err_count),
        .o_backlog       (backlog),
        .o_fired         (fired_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver stall: alternating stretches, mostly short stalls, a few long,
    // and open stretches with no stall at all.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    i_out_stall <= 1'b0;
                    stall_hold  <= $urandom_range(0, 20);
                end
                4, 5, 6, 7: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(0, 3);
                end
                8: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(4, 12);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(20, 40);
                end
            endcase
        end
    end

    // Watchdog: any cycle with no beat on either side and no register write
    // counts as quiet; too many in a row means the block has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d quiet cycles, %0d beats still due", quiet_cycles, backlog);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [STATE_BITS-1:0] any_state();
        return STATE_BITS'($urandom_range(0, (1 << STATE_BITS) - 1));
    endfunction

    // Mostly the codes the table reacts to, so ticks keep firing transitions
    function automatic logic [EVENT_BITS-1:0] pick_event();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return EVENT_BITS'(0);
            2, 3:    return EVENT_BITS'(1);
            4:       return EVENT_BITS'(2);
            5:       return EVENT_BITS'(3);
            6, 7:    return '1;
            default: return EVENT_BITS'($urandom_range(0, (1 << EVENT_BITS) - 1));
        endcase
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One request beat. Valid stays high after acceptance; the next call
    // either reloads the payload in the same step or drops valid for a gap.
    task automatic send(input logic [REQ_W-1:0]      req,
                        input logic [STATE_BITS-1:0] from_st,
                        input logic [EVENT_BITS-1:0] on_ev,
                        input logic [STATE_BITS-1:0] to_st,
                        input logic [EVENT_BITS-1:0] code);
        int gap;
        gap = steady_phase ? 0 : draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_from_state <= from_st;
        i_on_event   <= on_ev;
        i_to_state   <= to_st;
        i_event_code <= code;
        do @(posedge i_clk); while (o_in_stall);
        case (req)
            REQ_APPEND: n_append++;
            REQ_POST:   n_post++;
            REQ_TICK:   n_tick++;
            default:    n_ignored++;
        endcase
        if (req != REQ_UNUSED) items_sent++;
    endtask

    task automatic post_event(input logic [EVENT_BITS-1:0] code);
        send(REQ_POST, any_state(), pick_event(), any_state(), code);
    endtask

    task automatic run_tick();
        send(REQ_TICK, any_state(), pick_event(), any_state(), pick_event());
    endtask

    // Drop valid and hold off until every predicted beat has been taken.
    // The backlog count is registered, so the loop waits for an edge before it samples.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
    endtask

    // Back-to-back writes of all three action masks
    task automatic program_masks(input logic [MASK_W-1:0] exit_m,
                                 input logic [MASK_W-1:0] entry_m,
                                 input logic [MASK_W-1:0] update_m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXIT_MASK;
        i_cfg_data <= exit_m;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ENTRY_MASK;
        i_cfg_data <= entry_m;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UPDATE_MASK;
        i_cfg_data <= update_m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [11:0] ent;
        int          phase_end;
        int          k;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part ----------------
        // exit actions everywhere, no entry actions, update on the four used states
        program_masks('1, '0, 16'h8421);

        // fill the table completely, then one append that must bounce
        for (int e = 0; e < 16; e++) begin
            ent = SEED_TABLE[e*12 +: 12];
            send(REQ_APPEND, ent[11:8], ent[7:4], ent[3:0], pick_event());
        end
        send(REQ_APPEND, '1, '1, '1, '1);

        // ring holds QUEUE_SLOTS-1 codes: the fourth post is dropped
        post_event('0);
        post_event('1);
        post_event(EVENT_BITS'(1));
        post_event(EVENT_BITS'(2));

        // 0 --ev0--> triple match ending in 15; 15 --ev15--> 0; 0 --ev1--> 10;
        // then a tick on the empty ring that reports only the done beat
        repeat (4) run_tick();

        // unused request code, no beat expected
        send(REQ_UNUSED, '0, '1, '0, '1);

        // ---------------- random phases ----------------
        for (int ph = 1; ph <= PHASES; ph++) begin
            // masks change only with the block idle
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (ph)
                1:       program_masks('0, '0, '0);
                2:       program_masks('1, '1, '1);
                3:       program_masks(16'h0401, 16'h8020, 16'hA5A5);
                default: program_masks(MASK_W'($urandom), MASK_W'($urandom),
                                       MASK_W'($urandom));
            endcase
            // one phase runs flat out on the sender side
            steady_phase = (ph == 3);
            phase_end = items_sent + PHASE_ITEMS;

            while (items_sent < phase_end) begin
                case ($urandom_range(0, 19))
                    // the common shape: a few posts, then as many ticks
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                        k = $urandom_range(1, QUEUE_SLOTS - 1);
                        repeat (k) post_event(pick_event());
                        repeat (k) run_tick();
                    end
                    // overrun the ring, then drain it plus one empty tick
                    13, 14: begin
                        repeat (QUEUE_SLOTS + 1) post_event(pick_event());
                        repeat (QUEUE_SLOTS) run_tick();
                    end
                    // stray tick, often on an empty ring
                    15, 16: run_tick();
                    // append into the full table
                    17: send(REQ_APPEND, any_state(), pick_event(), any_state(),
                             pick_event());
                    // noise the block should ignore
                    18: send(REQ_UNUSED, any_state(), pick_event(), any_state(),
                             pick_event());
                    // sender holds back until the result side has caught up
                    default: drain_results();
                endcase
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d appends, %0d posts, %0d ticks, %0d ignored requests",
                 n_append, n_post, n_tick, n_ignored);
        $display("%0d transitions fired over %0d action mask settings",
                 fired_count, n_settings);
        if (err_count == 0 && backlog == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
